### rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Default geometry of the text screen.
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  // Command codes carried on the input beat.
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_READ,
    ST_OUT
  } state_t;

  // Character codes with a special meaning.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Attribute after reset: white on black.
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // Register index of the attribute register.
  localparam logic [0:0] REG_ATTRIBUTE = 1'b0;

  // Control flags from the cursor step unit.
  typedef struct packed {
    logic wr_en;
    logic scroll;
  } step_flags_t;

endpackage

`default_nettype wire

### rtl/core/text_console_cell_writer.sv
`default_nettype none

// Text console cell writer: a ROWS x COLUMNS store of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor, driven by one command
// beat at a time and answering each with one result beat that carries the cursor
// index and, for a read, the cell. All store traffic goes through one memory with
// one write and one registered read port, walked by a small sequencer. A put that
// does not scroll, a read outside the screen, and an unused opcode pass through
// accept, execute and result; a read of a cell on the screen passes through
// accept, execute, store read and result. A put that scrolls copies the store
// up one row at one cell a cycle, then blanks the last row one cell a cycle,
// before its result. A clear blanks every cell and homes the cursor.
// After reset, a clearing pass writes a blank with attribute 0x0F into every cell;
// in_tready stays low until it is done, while register writes are taken at any
// time. The next command is accepted after the result beat has been taken.
module text_console_cell_writer #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] char_code, [12:8] read_row, [19:13] read_col
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [10:0] cursor_index, [26:11] read_data
  // Register port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int PH_W      = $clog2(TAB_STOP);
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);
  localparam logic [IDX_W-1:0] COPY_LAST = IDX_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [IDX_W-1:0] ROW_STEP  = IDX_W'(COLUMNS);

  tcw_pkg::state_t  state_r, state_nxt;

  logic [7:0]       attr_r;
  tcw_pkg::opcode_t cmd_op_r;
  logic [7:0]       cmd_char_r;
  logic [4:0]       cmd_row_r;
  logic [6:0]       cmd_col_r;

  logic [COL_W-1:0] cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0] cursor_row_r, cursor_row_nxt;
  logic [PH_W-1:0]  tab_phase_r, tab_phase_nxt;

  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [15:0]      out_data_r, out_data_nxt;

  logic [15:0]      cells_r [CELLS];
  logic [15:0]      rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  logic [COL_W-1:0] step_col, step_wr_col;
  logic [ROW_W-1:0] step_row;
  logic [PH_W-1:0]  step_phase;
  logic [7:0]       step_wr_char;
  tcw_pkg::step_flags_t step_flags;

  logic [IDX_W-1:0] row_base;
  logic [IDX_W-1:0] cursor_idx;
  logic             read_in_range;
  logic [IDX_W-1:0] read_addr;
  logic             in_beat;
  logic             cfg_write;

  // Handshakes.
  assign in_tready  = (state_r == tcw_pkg::ST_IDLE);
  assign out_tvalid = (state_r == tcw_pkg::ST_OUT);
  assign in_beat    = in_tvalid && in_tready;

  // Register port: one attribute register at index 0.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tcw_pkg::REG_ATTRIBUTE) ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_write && (cfg_paddr[2] == tcw_pkg::REG_ATTRIBUTE)) begin
      attr_r <= cfg_pwdata[7:0];
    end
  end

  // Cursor arithmetic: row base of the cursor and of a read request.
  assign row_base      = IDX_W'(IDX_W'(cursor_row_r) * ROW_STEP);
  assign cursor_idx    = row_base + IDX_W'(cursor_col_r);
  assign read_in_range = (7'(cmd_row_r) < 7'(ROWS)) && (8'(cmd_col_r) < 8'(COLUMNS));
  assign read_addr     = IDX_W'(IDX_W'(cmd_row_r) * ROW_STEP) + IDX_W'(cmd_col_r);

  // Result beat.
  assign out_tdata = {5'd0, out_data_r, 11'(cursor_idx)};

  tcw_cursor_step #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_step (
    .char_code (cmd_char_r),
    .col_i     (cursor_col_r),
    .row_i     (cursor_row_r),
    .phase_i   (tab_phase_r),
    .col_o     (step_col),
    .row_o     (step_row),
    .phase_o   (step_phase),
    .wr_col_o  (step_wr_col),
    .wr_char_o (step_wr_char),
    .flags_o   (step_flags)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        if (ptr_r == LAST_CELL) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_beat) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        unique case (cmd_op_r)
          tcw_pkg::OP_PUT: begin
            state_nxt = step_flags.scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_OUT;
          end
          tcw_pkg::OP_CLEAR: state_nxt = tcw_pkg::ST_FILL;
          tcw_pkg::OP_READ: begin
            state_nxt = read_in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_OUT;
          end
          tcw_pkg::OP_NONE: state_nxt = tcw_pkg::ST_OUT;
        endcase
      end
      tcw_pkg::ST_COPY: begin
        if (ptr_r == COPY_LAST) state_nxt = tcw_pkg::ST_DRAIN;
      end
      tcw_pkg::ST_DRAIN: state_nxt = tcw_pkg::ST_FILL;
      tcw_pkg::ST_FILL: begin
        if (ptr_r == LAST_CELL) state_nxt = tcw_pkg::ST_OUT;
      end
      tcw_pkg::ST_READ: state_nxt = tcw_pkg::ST_OUT;
      tcw_pkg::ST_OUT: begin
        if (out_tready) state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control. A pending copy beat is written in the cycle after its read.
  always_comb begin
    ptr_nxt        = ptr_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    tab_phase_nxt  = tab_phase_r;
    out_data_nxt   = out_data_r;
    mem_we         = pend_r;
    mem_waddr      = pend_addr_r;
    mem_wdata      = rdata_r;
    mem_raddr      = ptr_r + ROW_STEP;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
        ptr_nxt   = (ptr_r == LAST_CELL) ? '0 : ptr_r + 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        ptr_nxt = '0;
      end
      tcw_pkg::ST_EXEC: begin
        out_data_nxt = '0;
        unique case (cmd_op_r)
          tcw_pkg::OP_PUT: begin
            mem_we         = step_flags.wr_en;
            mem_waddr      = row_base + IDX_W'(step_wr_col);
            mem_wdata      = {attr_r, step_wr_char};
            cursor_col_nxt = step_col;
            cursor_row_nxt = step_row;
            tab_phase_nxt  = step_phase;
          end
          tcw_pkg::OP_CLEAR: begin
            cursor_col_nxt = '0;
            cursor_row_nxt = '0;
            tab_phase_nxt  = '0;
          end
          tcw_pkg::OP_READ: begin
            mem_raddr = read_addr;
          end
          tcw_pkg::OP_NONE: begin
            out_data_nxt = '0;
          end
        endcase
      end
      tcw_pkg::ST_COPY: begin
        pend_nxt      = 1'b1;
        pend_addr_nxt = ptr_r;
        ptr_nxt       = ptr_r + 1'b1;
      end
      tcw_pkg::ST_DRAIN: begin
        ptr_nxt = ptr_r;
      end
      tcw_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = {attr_r, tcw_pkg::CH_SPACE};
        ptr_nxt   = (ptr_r == LAST_CELL) ? '0 : ptr_r + 1'b1;
      end
      tcw_pkg::ST_READ: begin
        out_data_nxt = rdata_r;
      end
      tcw_pkg::ST_OUT: begin
        ptr_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::ST_INIT;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      tab_phase_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      pend_r       <= pend_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      tab_phase_r  <= tab_phase_nxt;
    end
  end

  // Payload registers: command capture, copy address and result data.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_op_r   <= tcw_pkg::opcode_t'(in_tuser);
      cmd_char_r <= in_tdata[7:0];
      cmd_row_r  <= in_tdata[12:8];
      cmd_col_r  <= in_tdata[19:13];
    end
    pend_addr_r <= pend_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= cells_r[mem_raddr];
  end

`ifndef NO_ASSERTIONS
  // An accepted command is executed in the very next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == tcw_pkg::ST_EXEC))
    else $error("accepted command was not executed next");

  // The stored cursor always lies on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cursor_col_r) < COLUMNS) && (int'(cursor_row_r) < ROWS))
    else $error("cursor left the screen");

  // A pending copy write only follows a copy read.
  a_pend_copy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == tcw_pkg::ST_COPY))
    else $error("copy write without a copy read");

  // The store is quiet while a result beat is offered.
  a_quiet_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !mem_we)
    else $error("store written while the result beat waits");
`endif

endmodule

`default_nettype wire

### rtl/core/tcw_cursor_step.sv
`default_nettype none

module tcw_cursor_step #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF,
  localparam int COL_W   = $clog2(COLUMNS),
  localparam int ROW_W   = $clog2(ROWS),
  localparam int PH_W    = $clog2(TAB_STOP)
) (
  input  wire logic [7:0]         char_code,
  input  wire logic [COL_W-1:0]   col_i,
  input  wire logic [ROW_W-1:0]   row_i,
  input  wire logic [PH_W-1:0]    phase_i,
  output logic [COL_W-1:0]        col_o,
  output logic [ROW_W-1:0]        row_o,
  output logic [PH_W-1:0]         phase_o,
  output logic [COL_W-1:0]        wr_col_o,
  output logic [7:0]              wr_char_o,
  output tcw_pkg::step_flags_t    flags_o
);

  // The column may overshoot the last column by up to a tab stop before it wraps,
  // and the row may reach ROWS before it scrolls.
  localparam int CX_W = $clog2(COLUMNS + TAB_STOP);
  localparam int RX_W = $clog2(ROWS + 1);

  logic [CX_W-1:0] col_x;
  logic [RX_W-1:0] row_x;
  logic [PH_W-1:0] phase_x;

  // Cursor motion for one character. The phase tracks the column modulo the
  // tab stop, so a tab needs only one subtraction.
  always_comb begin
    col_x          = CX_W'(col_i);
    row_x          = RX_W'(row_i);
    phase_x        = phase_i;
    wr_col_o       = col_i;
    wr_char_o      = char_code;
    flags_o        = '0;
    priority if (char_code == tcw_pkg::CH_BS) begin
      flags_o.wr_en = 1'b1;
      wr_char_o     = tcw_pkg::CH_NUL;
      if (col_i != '0) begin
        wr_col_o = col_i - 1'b1;
        col_x    = CX_W'(col_i) - 1'b1;
        phase_x  = (phase_i == '0) ? PH_W'(TAB_STOP - 1) : phase_i - 1'b1;
      end
    end else if (char_code == tcw_pkg::CH_TAB) begin
      col_x   = CX_W'(col_i) + CX_W'(TAB_STOP) - CX_W'(phase_i);
      phase_x = '0;
    end else if (char_code == tcw_pkg::CH_CR) begin
      col_x   = '0;
      phase_x = '0;
    end else if (char_code == tcw_pkg::CH_LF) begin
      col_x   = '0;
      row_x   = row_x + 1'b1;
      phase_x = '0;
    end else if (char_code >= tcw_pkg::CH_SPACE) begin
      flags_o.wr_en = 1'b1;
      col_x         = col_x + 1'b1;
      phase_x       = (phase_i == PH_W'(TAB_STOP - 1)) ? '0 : phase_i + 1'b1;
    end else begin
      col_x = CX_W'(col_i);
    end

    // Running past the last column wraps to the next row.
    if (col_x >= CX_W'(COLUMNS)) begin
      col_x   = '0;
      row_x   = row_x + 1'b1;
      phase_x = '0;
    end

    // Running past the last row pins the cursor on the last row and asks for a scroll.
    if (row_x >= RX_W'(ROWS)) begin
      flags_o.scroll = 1'b1;
      row_x          = RX_W'(ROWS - 1);
    end

    col_o   = COL_W'(col_x);
    row_o   = ROW_W'(row_x);
    phase_o = phase_x;
  end

endmodule

`default_nettype wire

### verif/text_console_cell_checker.sv
// Watches the command, result and register channels of the text console cell
// writer, keeps its own copy of the screen, cursor and attribute, and compares
// every result beat against the oldest predicted one.
module text_console_cell_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_cnt
);
  import tcw_pkg::*;

  localparam int COLS      = COLUMNS_DEF;
  localparam int LINES     = ROWS_DEF;
  localparam int TAB_WIDTH = TAB_STOP_DEF;
  localparam int CELLS     = COLS * LINES;
  localparam int SHOW_MAX  = 10;

  // Result beat layout: read_data above cursor_index.
  typedef struct packed {
    logic [15:0] read_data;
    logic [10:0] cursor_index;
  } console_result_t;

  logic [15:0]     screen [CELLS];
  int unsigned     cur_col;
  int unsigned     cur_row;
  logic [7:0]      attr;
  console_result_t result_q [$];
  int              mismatches = 0;

  // Fill a run of cells with a space in the current attribute.
  function automatic void blank_cells(input int first, input int count);
    for (int i = first; i < first + count && i < CELLS; i++) begin
      screen[i] = {attr, CH_SPACE};
    end
  endfunction

  function automatic void store_at_cursor(input logic [15:0] value);
    int unsigned pos;
    pos = cur_row * COLS + cur_col;
    if (pos < CELLS) screen[pos] = value;
  endfunction

  // One character written to the console, control codes included.
  function automatic void put_char(input logic [7:0] ch);
    case (ch)
      CH_BS: begin
        if (cur_col > 0) cur_col--;
        store_at_cursor({attr, CH_NUL});
      end
      CH_TAB: cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
      CH_CR:  cur_col = 0;
      CH_LF: begin
        cur_col = 0;
        cur_row++;
      end
      default: begin
        if (ch >= CH_SPACE) begin
          store_at_cursor({attr, ch});
          cur_col++;
        end
      end
    endcase

    // Wrap at the right edge.
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end

    // Scroll the screen up one line past the bottom.
    if (cur_row >= LINES) begin
      for (int i = 0; i < (LINES - 1) * COLS; i++) begin
        screen[i] = screen[i + COLS];
      end
      blank_cells((LINES - 1) * COLS, COLS);
      cur_row = LINES - 1;
    end
  endfunction

  function automatic console_result_t predict_command(input opcode_t op,
                                                      input logic [7:0] ch,
                                                      input logic [4:0] rr,
                                                      input logic [6:0] rc);
    console_result_t r;
    int unsigned     pos;
    r.read_data = '0;
    case (op)
      OP_PUT: put_char(ch);
      OP_CLEAR: begin
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        if (int'(rr) < LINES && int'(rc) < COLS) r.read_data = screen[int'(rr) * COLS + int'(rc)];
      end
      default: ;
    endcase
    pos = cur_row * COLS + cur_col;
    r.cursor_index = pos[10:0];
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    fail_count++;
    if (mismatches < SHOW_MAX) begin
      $display("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    end
    mismatches++;
  endtask

  // All three channels are sampled at the rising edge, before any update lands.
  always @(posedge clk) begin : watch
    console_result_t got;
    console_result_t want;
    if (!rst_n) begin
      attr = ATTR_RESET;
      blank_cells(0, CELLS);
      cur_col = 0;
      cur_row = 0;
      result_q.delete();
    end else begin
      // Result beats are compared first; they belong to earlier commands.
      if (out_tvalid && out_tready) begin
        got = out_tdata[26:0];
        if (result_q.size() == 0) begin
          fail_count++;
          if (mismatches < SHOW_MAX) begin
            $display("unexpected result beat: cursor 0x%0h, data 0x%0h",
                     got.cursor_index, got.read_data);
          end
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (got.cursor_index !== want.cursor_index) begin
            note_mismatch("cursor_index", int'(want.cursor_index), int'(got.cursor_index));
          end
          if (got.read_data !== want.read_data) begin
            note_mismatch("read_data", int'(want.read_data), int'(got.read_data));
          end
        end
      end

      // Register writes; only the attribute index is backed by a register.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2:2] == REG_ATTRIBUTE) attr = cfg_pwdata[7:0];
      end

      if (in_tvalid && in_tready) begin
        result_q.push_back(predict_command(opcode_t'(in_tuser), in_tdata[7:0],
                                           in_tdata[12:8], in_tdata[19:13]));
      end
    end
    pending_cnt <= result_q.size();
  end

endmodule

### verif/tb_text_console_cell_writer.sv
module tb_text_console_cell_writer;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 400;
  localparam int SETTLE_CYCLES  = 50;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // [7:0] char_code, [12:8] read_row, [19:13] read_col
  logic [1:0]  in_tuser;    // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;   // [10:0] cursor_index, [26:11] read_data
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending_cnt;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_console_cell_writer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  text_console_cell_checker cell_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: ends the run after too many cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[text_console_cell_writer] ERROR");
        $finish;
      end
    end
  end

  // Offer one command beat and wait until it is taken.
  task automatic send_cmd(input opcode_t op, input logic [7:0] ch,
                          input logic [4:0] rr, input logic [6:0] rc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, rc, rr, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // Mostly text with line breaks so the cursor reaches the bottom and scrolls;
  // reads favor the bottom rows where the recent text lands.
  task automatic send_random_cmd();
    int         pick;
    int         sel;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    pick = $urandom_range(999);
    sel  = $urandom_range(99);
    ch   = 8'($urandom);
    rr   = 5'($urandom);
    rc   = 7'($urandom);
    if (pick < 2) begin
      send_cmd(OP_CLEAR, ch, rr, rc);
    end else if (pick < 25) begin
      send_cmd(OP_NONE, ch, rr, rc);
    end else if (pick < 175) begin
      if (sel < 40) begin
        rr = 5'($urandom_range(ROWS_DEF - 1, ROWS_DEF - 3));
        rc = 7'($urandom_range(COLUMNS_DEF - 1));
      end else if (sel < 85) begin
        rr = 5'($urandom_range(ROWS_DEF - 1));
        rc = 7'($urandom_range(COLUMNS_DEF - 1));
      end else if (sel < 93) begin
        rr = 5'($urandom_range(31, ROWS_DEF));
      end else begin
        rc = 7'($urandom_range(127, COLUMNS_DEF));
      end
      send_cmd(OP_READ, ch, rr, rc);
    end else begin
      if (sel < 10) ch = CH_LF;
      else if (sel < 13) ch = CH_CR;
      else if (sel < 18) ch = CH_TAB;
      else if (sel < 23) ch = CH_BS;
      else if (sel < 26) ch = 8'($urandom_range(31));
      else ch = 8'($urandom_range(255, 32));
      send_cmd(OP_PUT, ch, rr, rc);
    end
  endtask

  initial begin : stimulus
    logic [7:0]  phase_attr;
    logic [31:0] attr_word;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_PUT;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Let the power-on clearing pass finish before touching the attribute.
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    write_reg({REG_ATTRIBUTE, 2'b00}, 32'h0000_001E);
    // A write to the unused index must leave the attribute alone.
    write_reg({~REG_ATTRIBUTE, 2'b00}, 32'hFFFF_FFFF);

    // Directed commands: reset contents, reads out of range, the unused
    // opcode, control codes, backspace at column 0, tabs and a clear.
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'hFF, 5'd24, 7'd79);
    send_cmd(OP_READ, 8'h00, 5'd31, 7'd127);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd80);
    send_cmd(OP_READ, 8'h00, 5'd25, 7'd0);
    send_cmd(OP_NONE, 8'hFF, 5'd31, 7'd127);
    send_cmd(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_cmd(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_NUL, 5'd0, 7'd0);
    send_cmd(OP_PUT, 8'h1F, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_CR, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_SPACE, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_LF, 5'd0, 7'd0);
    send_cmd(OP_PUT, 8'h7F, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd1);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd16);
    send_cmd(OP_READ, 8'h00, 5'd1, 7'd0);
    send_cmd(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd0);

    // Random phases, each with its own attribute and idling pattern.
    for (int phase = 0; phase < 4; phase++) begin
      wait_results();
      case (phase)
        0: begin
          phase_attr = 8'h00;
          send_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          phase_attr = 8'hFF;
          send_idle_pct = 54;
          sink_stall_pct = 0;
        end
        2: begin
          phase_attr = 8'($urandom);
          send_idle_pct = 0;
          sink_stall_pct = 54;
        end
        default: begin
          phase_attr = ATTR_RESET;
          send_idle_pct = 22;
          sink_stall_pct = 22;
        end
      endcase
      attr_word = $urandom;
      attr_word[7:0] = phase_attr;
      write_reg({REG_ATTRIBUTE, 2'b00}, attr_word);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The receiver backs off for a long stretch while commands keep coming.
        if (phase == 1 && n == PHASE_ITEMS / 3) hold_req++;
        // The sender goes quiet until the block has answered everything.
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_results();
        send_random_cmd();
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("[text_console_cell_writer] OK");
    end else begin
      $display("[text_console_cell_writer] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_cursor_step.sv
rtl/core/text_console_cell_writer.sv
verif/text_console_cell_checker.sv
verif/tb_text_console_cell_writer.sv
